// ===== hw/rtl/tsd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsd_pkg
// shared types, constants and the crc-8 byte step for the scratchpad decoder
// ----------------------------------------------------------------------------
package tsd_pkg;

    localparam int unsigned ADDR_W     = 4;
    localparam int unsigned DATA_W     = 32;
    localparam int unsigned BYTE_IDX_W = 4;

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [DATA_W-1:0] t_data;
    typedef logic [BYTE_IDX_W-1:0] t_byte_idx;
    typedef logic signed [15:0] t_temp;
    typedef logic signed [11:0] t_cal;

    typedef enum logic [1:0] {
        REG_FAMILY = 2'd0,
        REG_FOUND  = 2'd1,
        REG_CAL    = 2'd2
    } t_reg_idx;

    typedef enum logic [1:0] {
        ST_VALID    = 2'd0,
        ST_CRC_FAIL = 2'd1,
        ST_NO_SENSE = 2'd2
    } t_status;

    localparam logic [7:0] FAMILY_NINE_BIT = 8'h10;
    localparam logic [7:0] FAMILY_RESET    = 8'h28;
    localparam logic [7:0] CPD_FULL        = 8'h10;
    localparam logic [7:0] CRC_POLY_REFL   = 8'h8C;
    localparam t_byte_idx  IDX_TEMP_LO     = 4'd0;
    localparam t_byte_idx  IDX_TEMP_HI     = 4'd1;
    localparam t_byte_idx  IDX_RES         = 4'd4;
    localparam t_byte_idx  IDX_CNT_REM     = 4'd6;
    localparam t_byte_idx  IDX_CNT_PER     = 4'd7;
    localparam t_byte_idx  IDX_CRC         = 4'd8;
    localparam t_temp      TEMP_CRC_FAIL   = -16'sd944;
    localparam t_temp      TEMP_NO_SENSOR  = -16'sd960;

    function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY_REFL;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/temp_scratchpad_decoder_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// temp_scratchpad_decoder_top
// decodes the nine scratchpad bytes of a 1-wire thermometer into a reading
//
// input stream: one scratchpad byte per transaction, byte 0 first; the block
// counts bytes itself and runs the crc-8 over bytes 0 to 7
// output stream: one transaction after every byte 8, temperature in sixteenths
// of a degree on tdata, status on tuser (valid, crc failed, no sensor)
// after byte 8 is accepted the result passes the conversion register, then
// the calibration add and saturate into the output register
// throughput: one byte per cycle while s_tready is high, set by the byte-wide crc step
// when the receiver stalls, the two result registers fill and then s_tready
// drops; no transaction is lost
// reset: byte count and crc clear, registers return to family 0x28, no sensor,
// zero calibration; the apb port writes registers at any time, pready is
// always high
// ----------------------------------------------------------------------------
module temp_scratchpad_decoder_top (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_s_tvalid,
    output logic             o_s_tready,
    input  wire  [7:0]       i_s_tdata,   // [7:0] scratch_byte
    output logic             o_m_tvalid,
    input  wire              i_m_tready,
    output logic [15:0]      o_m_tdata,   // [15:0] temperature
    output logic [1:0]       o_m_tuser,   // [1:0] status
    input  wire              psel,
    input  wire              penable,
    input  wire              pwrite,
    input  wire  tsd_pkg::t_addr paddr,
    input  wire  tsd_pkg::t_data pwdata,
    output tsd_pkg::t_data   prdata,
    output logic             pready
);
    import tsd_pkg::*;

    logic [7:0] r_family;
    logic       r_found;
    t_cal       r_cal;

    t_byte_idx  r_idx;
    logic [7:0] r_crc;
    logic [7:0] r_tlo, r_thi, r_res, r_crem, r_cper;

    logic       r_s1_valid;
    t_temp      r_s1_temp;
    t_status    r_s1_status;

    logic       r_out_valid;
    t_temp      r_out_temp;
    t_status    r_out_status;

    logic       s_acc, s1_adv, out_free, is_last, cfg_wr;
    t_byte_idx  eff_idx;
    t_reg_idx   reg_sel;
    logic [15:0] raw16, n_raw;
    logic signed [16:0] sum;
    t_temp      n_out_temp;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign reg_sel  = t_reg_idx'(paddr[3:2]);

    always_comb begin
        prdata = '0;
        case (reg_sel)
            REG_FAMILY: prdata = {24'd0, r_family};
            REG_FOUND:  prdata = {31'd0, r_found};
            REG_CAL:    prdata = {20'd0, r_cal};
            default:    prdata = '0;
        endcase
    end

    // handshake
    assign out_free   = !r_out_valid || i_m_tready;
    assign s1_adv     = r_s1_valid && out_free;
    assign o_s_tready = !r_s1_valid || out_free;
    assign s_acc      = i_s_tvalid && o_s_tready;
    assign eff_idx    = (r_idx > IDX_CRC) ? IDX_TEMP_LO : r_idx;
    assign is_last    = (eff_idx == IDX_CRC);

    // conversion of the captured bytes
    always_comb begin
        raw16 = {r_thi, r_tlo};
        n_raw = raw16;
        if (r_family == FAMILY_NINE_BIT) begin
            n_raw = raw16 << 3;
            if (r_cper == CPD_FULL) begin
                n_raw = (n_raw & 16'hFFF0) + 16'd12 - {8'd0, r_crem};
            end
        end else begin
            case (r_res[6:5])
                2'b00:   n_raw = raw16 & 16'hFFF8;
                2'b01:   n_raw = raw16 & 16'hFFFC;
                2'b10:   n_raw = raw16 & 16'hFFFE;
                default: n_raw = raw16;
            endcase
        end
    end

    // calibration add and saturate, applied to valid readings only
    always_comb begin
        sum = {r_s1_temp[15], r_s1_temp} + 17'(signed'(r_cal));
        if (r_s1_status != ST_VALID) begin
            n_out_temp = r_s1_temp;
        end else if (sum[16] != sum[15]) begin
            n_out_temp = sum[16] ? 16'sh8000 : 16'sh7FFF;
        end else begin
            n_out_temp = sum[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_family    <= FAMILY_RESET;
            r_found     <= 1'b0;
            r_cal       <= '0;
            r_idx       <= '0;
            r_crc       <= '0;
            r_tlo       <= '0;
            r_thi       <= '0;
            r_res       <= '0;
            r_crem      <= '0;
            r_cper      <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (cfg_wr) begin
                case (reg_sel)
                    REG_FAMILY: r_family <= pwdata[7:0];
                    REG_FOUND:  r_found  <= pwdata[0];
                    REG_CAL:    r_cal    <= pwdata[11:0];
                    default:    ;
                endcase
            end

            if (s_acc) begin
                if (is_last) begin
                    r_idx <= '0;
                    r_crc <= '0;
                end else begin
                    r_idx <= eff_idx + 4'd1;
                    r_crc <= crc_byte(r_crc, i_s_tdata);
                    case (eff_idx)
                        IDX_TEMP_LO: r_tlo  <= i_s_tdata;
                        IDX_TEMP_HI: r_thi  <= i_s_tdata;
                        IDX_RES:     r_res  <= i_s_tdata;
                        IDX_CNT_REM: r_crem <= i_s_tdata;
                        IDX_CNT_PER: r_cper <= i_s_tdata;
                        default:     ;
                    endcase
                end
            end

            if (s_acc && is_last) begin
                r_s1_valid <= 1'b1;
                if (!r_found) begin
                    r_s1_temp   <= TEMP_NO_SENSOR;
                    r_s1_status <= ST_NO_SENSE;
                end else if (r_crc != i_s_tdata) begin
                    r_s1_temp   <= TEMP_CRC_FAIL;
                    r_s1_status <= ST_CRC_FAIL;
                end else begin
                    r_s1_temp   <= n_raw;
                    r_s1_status <= ST_VALID;
                end
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end

            if (s1_adv) begin
                r_out_valid  <= 1'b1;
                r_out_temp   <= n_out_temp;
                r_out_status <= r_s1_status;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_temp;
    assign o_m_tuser  = r_out_status;

endmodule
`default_nettype wire

// ===== tb/temp_scratchpad_decoder_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// temp_scratchpad_decoder_checker
// follows the register writes and the byte stream, computes the reading each
// completed scratchpad should give and compares it with every output
// transaction
// ----------------------------------------------------------------------------
module temp_scratchpad_decoder_checker
    import tsd_pkg::*;
(
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_s_tvalid,
    input  wire          i_s_tready,
    input  wire  [7:0]   i_s_tdata,   // [7:0] scratch_byte
    input  wire          i_m_tvalid,
    input  wire          i_m_tready,
    input  wire  [15:0]  i_m_tdata,   // [15:0] temperature
    input  wire  [1:0]   i_m_tuser,   // [1:0] status
    input  wire          i_psel,
    input  wire          i_penable,
    input  wire          i_pwrite,
    input  wire          i_pready,
    input  wire  t_addr  i_paddr,
    input  wire  t_data  i_pwdata,
    output int           o_fail_count,
    output int           o_pending,
    output int           o_checked
);

    typedef struct packed {
        t_temp   temp;
        t_status status;
    } t_reading;

    localparam logic [1:0] RES_9BIT  = 2'b00;
    localparam logic [1:0] RES_10BIT = 2'b01;
    localparam logic [1:0] RES_11BIT = 2'b10;

    logic [7:0] family;
    logic       found;
    t_cal       offset;

    t_byte_idx  byte_pos;
    logic [7:0] crc_run;
    logic [7:0] lo_byte;
    logic [7:0] hi_byte;
    logic [7:0] res_byte;
    logic [7:0] remain_byte;
    logic [7:0] per_degree_byte;

    t_reading   readings_due[$];

    always @(posedge i_clk) begin : watch
        t_reading   want;
        t_reading   got;
        logic [15:0] raw;
        logic [7:0] b;
        logic       mix;
        int         sum;
        if (!i_rst_n) begin
            family          = FAMILY_RESET;
            found           = 1'b0;
            offset          = '0;
            byte_pos        = IDX_TEMP_LO;
            crc_run         = '0;
            lo_byte         = '0;
            hi_byte         = '0;
            res_byte        = '0;
            remain_byte     = '0;
            per_degree_byte = '0;
            readings_due.delete();
            o_fail_count    = 0;
            o_checked       = 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[3:2])
                    REG_FAMILY: family = i_pwdata[7:0];
                    REG_FOUND:  found  = i_pwdata[0];
                    REG_CAL:    offset = i_pwdata[11:0];
                    default: ;
                endcase
            end

            if (i_m_tvalid && i_m_tready) begin
                got.temp   = i_m_tdata;
                got.status = t_status'(i_m_tuser);
                if (readings_due.size() == 0) begin
                    o_fail_count++;
                    $display("%0t: unexpected reading temperature %0d status %0d", $time,
                             got.temp, got.status);
                end else begin
                    want = readings_due.pop_front();
                    o_checked++;
                    if (got.temp !== want.temp) begin
                        o_fail_count++;
                        $display("%0t: temperature expected %0d actual %0d", $time,
                                 want.temp, got.temp);
                    end
                    if (got.status !== want.status) begin
                        o_fail_count++;
                        $display("%0t: status expected %0d actual %0d", $time,
                                 want.status, got.status);
                    end
                end
            end

            if (i_s_tvalid && i_s_tready) begin
                b = i_s_tdata;
                if (byte_pos != IDX_CRC) begin
                    // bitwise dallas crc, lsb first
                    for (int k = 0; k < 8; k++) begin
                        mix     = crc_run[0] ^ b[k];
                        crc_run = crc_run >> 1;
                        if (mix) begin
                            crc_run = crc_run ^ CRC_POLY_REFL;
                        end
                    end
                    case (byte_pos)
                        IDX_TEMP_LO: lo_byte         = b;
                        IDX_TEMP_HI: hi_byte         = b;
                        IDX_RES:     res_byte        = b;
                        IDX_CNT_REM: remain_byte     = b;
                        IDX_CNT_PER: per_degree_byte = b;
                        default: ;
                    endcase
                    byte_pos = byte_pos + 1'b1;
                end else begin
                    if (!found) begin
                        want.temp   = TEMP_NO_SENSOR;
                        want.status = ST_NO_SENSE;
                    end else if (crc_run != b) begin
                        want.temp   = TEMP_CRC_FAIL;
                        want.status = ST_CRC_FAIL;
                    end else begin
                        raw = {hi_byte, lo_byte};
                        if (family == FAMILY_NINE_BIT) begin
                            raw = raw << 3;
                            if (per_degree_byte == CPD_FULL) begin
                                raw = (raw & 16'hFFF0) + 16'd12 - {8'h00, remain_byte};
                            end
                        end else begin
                            case (res_byte[6:5])
                                RES_9BIT:  raw[2:0] = 3'b000;
                                RES_10BIT: raw[1:0] = 2'b00;
                                RES_11BIT: raw[0]   = 1'b0;
                                default: ;
                            endcase
                        end
                        sum = int'($signed(raw)) + int'(offset);
                        if (sum > 32767) begin
                            sum = 32767;
                        end else if (sum < -32768) begin
                            sum = -32768;
                        end
                        want.temp   = t_temp'(sum);
                        want.status = ST_VALID;
                    end
                    readings_due.push_back(want);
                    byte_pos = IDX_TEMP_LO;
                    crc_run  = '0;
                end
            end
        end
        o_pending = readings_due.size();
    end

endmodule

// ===== tb/temp_scratchpad_decoder_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// temp_scratchpad_decoder_top_test
// streams scratchpad frames into the decoder under a series of register
// settings, with random gaps and output stalls; a checker judges every reading
// ----------------------------------------------------------------------------
module temp_scratchpad_decoder_top_test;
    import tsd_pkg::*;

    localparam int QUIET_LIMIT = 1000;
    localparam int PHASES      = 9;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic [7:0]  s_tdata   = 8'h00;
    logic        m_tready  = 1'b0;
    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    t_addr       paddr     = '0;
    t_data       pwdata    = '0;

    wire         o_s_tready;
    wire         o_m_tvalid;
    wire  [15:0] o_m_tdata;
    wire  [1:0]  o_m_tuser;
    t_data       prdata;
    wire         pready;

    int          fail_count;
    int          readings_pending;
    int          readings_checked;

    bit          gaps_on   = 1'b0;
    bit          stalls_on = 1'b0;
    int          stall_left;
    int          quiet_cycles;
    int          bytes_sent;
    int          settings_used;
    logic [7:0]  scratch_bytes[$];

    always #5 clk = ~clk;

    temp_scratchpad_decoder_top uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    temp_scratchpad_decoder_checker reading_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (s_tdata),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (o_m_tdata),
        .i_m_tuser    (o_m_tuser),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (readings_pending),
        .o_checked    (readings_checked)
    );

    // receiver stalls in short bursts
    always @(negedge clk) begin
        if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else if (stalls_on && $urandom_range(0, 4) == 0) begin
            m_tready <= 1'b0;
            stall_left = $urandom_range(0, 2);
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge clk) begin
        if ((s_tvalid && o_s_tready) || (o_m_tvalid && m_tready) ||
            (psel && penable && pwrite && pready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic write_reg(input t_reg_idx idx, input t_data value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    // nine bytes; the crc byte is flipped in one bit when crc_ok is clear
    task automatic add_frame(input logic [7:0] lo, input logic [7:0] hi,
                             input logic [7:0] res, input logic [7:0] remain,
                             input logic [7:0] per_degree, input bit crc_ok);
        logic [7:0] body[0:7];
        logic [7:0] crc;
        body[0] = lo;
        body[1] = hi;
        body[2] = 8'($urandom);
        body[3] = 8'($urandom);
        body[4] = res;
        body[5] = 8'($urandom);
        body[6] = remain;
        body[7] = per_degree;
        crc = 8'h00;
        for (int k = 0; k < 8; k++) begin
            crc = crc_byte(crc, body[k]);
            scratch_bytes.push_back(body[k]);
        end
        if (!crc_ok) begin
            crc = crc ^ (8'h01 << $urandom_range(0, 7));
        end
        scratch_bytes.push_back(crc);
    endtask

    task automatic send_bytes(input int count);
        logic [7:0] b;
        int         gap;
        repeat (count) begin
            b = scratch_bytes.pop_front();
            if (gaps_on && $urandom_range(0, 4) == 0) begin
                gap = $urandom_range(1, 3);
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= b;
            @(posedge clk);
            while (!o_s_tready) @(posedge clk);
            @(negedge clk);
            bytes_sent++;
        end
    endtask

    // hold the stream until every reading is back and the pipeline is empty
    task automatic settle();
        s_tvalid <= 1'b0;
        while (readings_pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    initial begin
        logic [7:0] fam;
        logic [11:0] cal;
        logic [7:0] lo;
        logic [7:0] hi;
        int         chunk;
        int         kind;

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: no sensor at reset, then high saturation and a bad crc
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
        settings_used = 1;
        add_frame(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
        send_bytes(scratch_bytes.size());
        settle();
        write_reg(REG_FOUND, 32'd1);
        write_reg(REG_CAL, {20'd0, 12'h7FF});
        settings_used++;
        add_frame(8'hFF, 8'h7F, 8'h60, 8'h00, 8'h00, 1'b1);
        add_frame(8'h00, 8'h80, 8'h1F, 8'h0C, CPD_FULL, 1'b0);
        send_bytes(scratch_bytes.size());
        settle();

        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: begin fam = FAMILY_NINE_BIT; cal = 12'h800; end
                1: begin fam = 8'hFF;           cal = 12'h7FF; end
                2: begin fam = 8'h00;           cal = 12'h000; end
                default: begin
                    case ($urandom_range(0, 3))
                        0: fam = FAMILY_NINE_BIT;
                        1: fam = FAMILY_RESET;
                        default: fam = 8'($urandom);
                    endcase
                    case ($urandom_range(0, 4))
                        0: cal = 12'h800;
                        1: cal = 12'h7FF;
                        2: cal = 12'h000;
                        default: cal = 12'($urandom);
                    endcase
                end
            endcase
            write_reg(REG_FAMILY, {24'd0, fam});
            write_reg(REG_CAL, {20'd0, cal});
            write_reg(REG_FOUND, (phase == 4) ? 32'd0 : 32'd1);
            settings_used++;
            gaps_on   = (phase != PHASES - 1) && ($urandom_range(0, 3) != 0);
            stalls_on = (phase != PHASES - 1) && ($urandom_range(0, 3) != 0);

            // chunks end anywhere, so some settings change in the middle of a frame
            chunk = $urandom_range(120, 220);
            while (scratch_bytes.size() < chunk) begin
                kind = $urandom_range(0, 99);
                if (kind < 15) begin
                    repeat (9) scratch_bytes.push_back(8'($urandom));
                end else begin
                    if ($urandom_range(0, 3) == 0) begin
                        case ($urandom_range(0, 3))
                            0: hi = 8'h00;
                            1: hi = 8'h7F;
                            2: hi = 8'h80;
                            default: hi = 8'hFF;
                        endcase
                        lo = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                    end else begin
                        hi = 8'($urandom);
                        lo = 8'($urandom);
                    end
                    add_frame(lo, hi, 8'($urandom), 8'($urandom),
                              $urandom_range(0, 1) ? CPD_FULL : 8'($urandom), kind >= 30);
                end
            end
            send_bytes(chunk);
            settle();
        end

        repeat (8) @(negedge clk);
        $display("sent %0d scratchpad bytes under %0d register settings, %0d readings compared",
                 bytes_sent, settings_used, readings_checked);
        if (fail_count == 0 && readings_pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/tsd_pkg.sv
hw/rtl/temp_scratchpad_decoder_top.sv
tb/temp_scratchpad_decoder_checker.sv
tb/temp_scratchpad_decoder_top_test.sv
